/* sv/bls_pkg.sv */
`timescale 1ns / 1ps

package bls_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int BW_W   = 8;
    localparam int LAT_W  = 32;
    localparam int DUR_W  = 16;
    localparam int PRI_W  = 16;

    localparam logic [LAT_W-1:0] LAT_MAX = '1;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_BYTES_PER_CYCLE = 2'd0;
    localparam logic [1:0] REG_FIXED_LATENCY   = 2'd1;
    localparam logic [1:0] REG_SHARED_RW       = 2'd2;

    localparam logic [BW_W-1:0] BW_RESET = 8'd4;

    typedef struct packed {
        logic [BW_W-1:0] bytes_per_cycle;
        logic [BW_W-1:0] fixed_latency;
        logic            shared_read_write;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_BASE,
        S_FIN
    } t_state;

endpackage

/* sv/bls_if.sv */
`timescale 1ns / 1ps

interface bls_req_if #(
    parameter int STAMP_BITS = 48,
    parameter int SIZE_BITS  = 16
);
    logic                         valid;
    logic                         ready;
    logic [STAMP_BITS-1:0]        now_cycle;
    logic [SIZE_BITS-1:0]         request_size;
    logic                         write_req;
    logic [bls_pkg::PRI_W-1:0]    prior_latency;
    logic [bls_pkg::PRI_W-1:0]    prior_duration;

    modport source (
        output valid, now_cycle, request_size, write_req, prior_latency, prior_duration,
        input  ready
    );
    modport sink (
        input  valid, now_cycle, request_size, write_req, prior_latency, prior_duration,
        output ready
    );
endinterface

interface bls_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bls_pkg::LAT_W-1:0]    new_latency;
    logic [bls_pkg::DUR_W-1:0]    new_duration;

    modport source (
        output valid, new_latency, new_duration,
        input  ready
    );
    modport sink (
        input  valid, new_latency, new_duration,
        output ready
    );
endinterface

/* sv/bls_cfg.sv */
`timescale 1ns / 1ps

module bls_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bls_pkg::ADDR_W-1:0]   paddr,
    input  logic [bls_pkg::DATA_W-1:0]   pwdata,
    output logic [bls_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output bls_pkg::t_cfg                o_cfg
);

    bls_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_cycle   <= bls_pkg::BW_RESET;
            r_cfg.fixed_latency     <= '0;
            r_cfg.shared_read_write <= 1'b0;
        end else if (wr_en) begin
            priority case (reg_idx)
                bls_pkg::REG_BYTES_PER_CYCLE: begin
                    r_cfg.bytes_per_cycle <= pwdata[bls_pkg::BW_W-1:0];
                end
                bls_pkg::REG_FIXED_LATENCY: begin
                    r_cfg.fixed_latency <= pwdata[bls_pkg::BW_W-1:0];
                end
                bls_pkg::REG_SHARED_RW: begin
                    r_cfg.shared_read_write <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        priority case (reg_idx)
            bls_pkg::REG_BYTES_PER_CYCLE: begin
                prdata[bls_pkg::BW_W-1:0] = r_cfg.bytes_per_cycle;
            end
            bls_pkg::REG_FIXED_LATENCY: begin
                prdata[bls_pkg::BW_W-1:0] = r_cfg.fixed_latency;
            end
            bls_pkg::REG_SHARED_RW: begin
                prdata[0] = r_cfg.shared_read_write;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/bls_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, rounding up.
module bls_div #(
    parameter int SIZE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SIZE_BITS-1:0]       i_dividend,
    input  logic [bls_pkg::BW_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [SIZE_BITS-1:0]       o_burst
);

    localparam int CW = $clog2(SIZE_BITS + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [SIZE_BITS-1:0]       r_dvd;
    logic [SIZE_BITS-1:0]       r_quo;
    logic [bls_pkg::BW_W-1:0]   r_rem;
    logic [bls_pkg::BW_W:0]     trial;
    logic [bls_pkg::BW_W:0]     diff;
    logic                       fits;

    assign trial = {r_rem, r_dvd[SIZE_BITS-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign fits  = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SIZE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SIZE_BITS-2:0], 1'b0};
            r_rem <= fits ? diff[bls_pkg::BW_W-1:0] : trial[bls_pkg::BW_W-1:0];
            r_quo <= {r_quo[SIZE_BITS-2:0], fits};
        end
    end

    // Round up on a nonzero remainder; with a nonzero divisor this cannot overflow, since divisor > 1 then.
    assign o_done  = r_done;
    assign o_burst = r_quo + SIZE_BITS'(r_rem != '0);

endmodule

/* sv/bandwidth_latency_shaper.sv */
`timescale 1ns / 1ps
// Flow: a request is taken in S_IDLE; with shaping on, the serial divider (one quotient bit
// per cycle) works out the burst in S_DIV, then S_CALC, S_BASE and S_FIN follow; with
// bytes_per_cycle zero, S_DIV goes straight on to S_BASE and S_FIN. Requests are taken one
// at a time; the next is taken once the previous result sits in the output register, and
// S_FIN holds while that register still holds a result that the sink has not taken.
// Reset (synchronous, active low): both free stamps cleared, registers to defaults.
module bandwidth_latency_shaper #(
    parameter int STAMP_BITS = 48,
    parameter int SIZE_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bls_req_if.sink                      i_req,
    bls_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bls_pkg::ADDR_W-1:0]   paddr,
    input  logic [bls_pkg::DATA_W-1:0]   pwdata,
    output logic [bls_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int SW = STAMP_BITS;
    localparam int ZW = SIZE_BITS;
    localparam int EW = ((SW > bls_pkg::LAT_W) ? SW : bls_pkg::LAT_W) + 1;
    localparam int AW = ((SW > ZW) ? SW : ZW) + 1;
    localparam int DW = (ZW > bls_pkg::DUR_W) ? ZW : bls_pkg::DUR_W;
    localparam logic [SW-1:0] STAMP_MAX = '1;

    bls_pkg::t_cfg   cfg;
    bls_pkg::t_state r_state;
    bls_pkg::t_state n_state;

    logic [SW-1:0]              r_now;
    logic [ZW-1:0]              r_size;
    logic                       r_wr;
    logic [bls_pkg::PRI_W-1:0]  r_plat;
    logic [bls_pkg::PRI_W-1:0]  r_pdur;
    logic [SW-1:0]              r_rd_stamp;
    logic [SW-1:0]              r_wr_stamp;
    logic                       r_gt;
    logic [SW-1:0]              r_diff;
    logic [SW-1:0]              r_start;
    logic [SW-1:0]              r_base;
    logic [SW-1:0]              r_next_stamp;
    logic                       r_out_valid;
    logic [bls_pkg::LAT_W-1:0]  r_lat;
    logic [bls_pkg::DUR_W-1:0]  r_dur;
    logic                       r_div_kick;

    logic                       enabled;
    logic                       use_wr;
    logic [SW-1:0]              cur_stamp;
    logic [SW:0]                sub;
    logic [AW-1:0]              stamp_sum;
    logic [EW-1:0]              lat_sum;
    logic [DW-1:0]              dur_max;
    logic [ZW-1:0]              burst;
    logic                       div_done;
    logic                       div_start;
    logic                       req_ready;
    logic                       load_out;
    logic                       accept;

    bls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bls_div #(
        .SIZE_BITS (ZW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_size),
        .i_divisor  (cfg.bytes_per_cycle),
        .o_done     (div_done),
        .o_burst    (burst)
    );

    assign enabled   = cfg.bytes_per_cycle != '0;
    assign use_wr    = r_wr | cfg.shared_read_write;
    assign cur_stamp = use_wr ? r_wr_stamp : r_rd_stamp;
    assign accept    = i_req.valid & req_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bls_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = bls_pkg::S_DIV;
                end
            end
            bls_pkg::S_DIV: begin
                if (!enabled) begin
                    n_state = bls_pkg::S_BASE;
                end else if (div_done) begin
                    n_state = bls_pkg::S_CALC;
                end
            end
            bls_pkg::S_CALC: n_state = bls_pkg::S_BASE;
            bls_pkg::S_BASE: n_state = bls_pkg::S_FIN;
            bls_pkg::S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = bls_pkg::S_IDLE;
                end
            end
            default: n_state = bls_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        req_ready = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            bls_pkg::S_IDLE: req_ready = i_rst_n;
            bls_pkg::S_FIN:  load_out  = !r_out_valid || o_rsp.ready;
            default: begin
            end
        endcase
        // Start the divider on the first cycle after the request lands
        div_start = r_div_kick & enabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bls_pkg::S_IDLE;
            r_rd_stamp  <= '0;
            r_wr_stamp  <= '0;
            r_out_valid <= 1'b0;
            r_div_kick  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_div_kick <= accept;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out && enabled) begin
                if (use_wr) begin
                    r_wr_stamp <= r_next_stamp;
                end else begin
                    r_rd_stamp <= r_next_stamp;
                end
            end
        end
    end

    assign sub       = {1'b0, cur_stamp} - {1'b0, r_now};
    assign stamp_sum = AW'(r_start) + AW'(burst);
    assign lat_sum   = EW'(r_base) + EW'(cfg.fixed_latency);
    assign dur_max   = (DW'(burst) > DW'(r_pdur)) ? DW'(burst) : DW'(r_pdur);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now  <= i_req.now_cycle;
            r_size <= i_req.request_size;
            r_wr   <= i_req.write_req;
            r_plat <= i_req.prior_latency;
            r_pdur <= i_req.prior_duration;
        end
        if (r_state == bls_pkg::S_CALC) begin
            // No borrow and nonzero difference: timeline still busy
            r_gt    <= !sub[SW] && (sub[SW-1:0] != '0);
            r_diff  <= sub[SW-1:0];
            r_start <= sub[SW] ? r_now : cur_stamp;
        end
        if (r_state == bls_pkg::S_BASE) begin
            if (enabled && r_gt && r_diff > SW'(r_plat)) begin
                r_base <= r_diff;
            end else begin
                r_base <= SW'(r_plat);
            end
            r_next_stamp <= (stamp_sum > AW'(STAMP_MAX)) ? STAMP_MAX : stamp_sum[SW-1:0];
        end
        if (load_out) begin
            r_lat <= (lat_sum > EW'(bls_pkg::LAT_MAX)) ? bls_pkg::LAT_MAX
                                                        : lat_sum[bls_pkg::LAT_W-1:0];
            if (!enabled) begin
                r_dur <= r_pdur;
            end else if (dur_max > DW'(bls_pkg::DUR_MAX)) begin
                r_dur <= bls_pkg::DUR_MAX;
            end else begin
                r_dur <= dur_max[bls_pkg::DUR_W-1:0];
            end
        end
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.new_latency  = r_lat;
    assign o_rsp.new_duration = r_dur;

endmodule

/* dv/tb_bandwidth_latency_shaper.sv */
`timescale 1ns / 1ps

module tb_bandwidth_latency_shaper;

    localparam int STAMP_BITS    = 48;
    localparam int SIZE_BITS     = 16;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = SIZE_BITS + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [63:0] STAMP_LIMIT = (64'd1 << STAMP_BITS) - 64'd1;

    typedef struct packed {
        logic [STAMP_BITS-1:0]        now_cycle;
        logic [SIZE_BITS-1:0]         request_size;
        logic                         write_req;
        logic [bls_pkg::PRI_W-1:0]    prior_latency;
        logic [bls_pkg::PRI_W-1:0]    prior_duration;
    } t_request;

    typedef struct packed {
        logic [bls_pkg::LAT_W-1:0] new_latency;
        logic [bls_pkg::DUR_W-1:0] new_duration;
    } t_shaped;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bls_pkg::ADDR_W-1:0] paddr;
    logic [bls_pkg::DATA_W-1:0] pwdata;
    logic [bls_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    bls_req_if #(.STAMP_BITS(STAMP_BITS), .SIZE_BITS(SIZE_BITS)) req_if ();
    bls_rsp_if rsp_if ();

    bandwidth_latency_shaper #(
        .STAMP_BITS(STAMP_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Shadow copy of the block's registers and timelines
    logic [7:0]  cfg_bw;
    logic [7:0]  cfg_fixed;
    logic        cfg_shared;
    logic [63:0] read_free;
    logic [63:0] write_free;
    logic [63:0] clock_now;

    t_shaped shaped_results_q[$];

    int errors        = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int settings_count = 0;
    int idle_pct      = 25;
    int stall_pct     = 10;
    int hold_off_req  = 0;
    bit quiet         = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d, t=%0t)",
                 what, got, want, checked_count, $time);
        errors++;
    endtask

    function automatic logic [63:0] add_capped(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] limit);
        if (a >= limit || b > limit - a) begin
            return limit;
        end
        return a + b;
    endfunction

    function automatic t_shaped shape_request(t_request r);
        logic [63:0] now;
        logic [63:0] size;
        logic [63:0] burst;
        logic [63:0] base;
        logic [63:0] start;
        logic [63:0] stamp;
        logic [63:0] lat;
        logic [63:0] dur;
        logic        on_write;
        t_shaped     res;
        now  = 64'(r.now_cycle);
        size = 64'(r.request_size);
        if (cfg_bw != 0) begin
            burst = size / 64'(cfg_bw) + (((size % 64'(cfg_bw)) != 0) ? 64'd1 : 64'd0);
            on_write = r.write_req || cfg_shared;
            stamp = on_write ? write_free : read_free;
            dur = (burst > 64'(r.prior_duration)) ? burst : 64'(r.prior_duration);
            if (dur > 64'(bls_pkg::DUR_MAX)) begin
                dur = 64'(bls_pkg::DUR_MAX);
            end
            base = 64'(r.prior_latency);
            if (stamp > now && stamp - now > base) begin
                base = stamp - now;
            end
            lat = add_capped(base, 64'(cfg_fixed), 64'(bls_pkg::LAT_MAX));
            start = (stamp > now) ? stamp : now;
            stamp = add_capped(start, burst, STAMP_LIMIT);
            if (on_write) begin
                write_free = stamp;
            end else begin
                read_free = stamp;
            end
        end else begin
            lat = add_capped(64'(r.prior_latency), 64'(cfg_fixed), 64'(bls_pkg::LAT_MAX));
            dur = 64'(r.prior_duration);
        end
        res.new_latency  = lat[bls_pkg::LAT_W-1:0];
        res.new_duration = dur[bls_pkg::DUR_W-1:0];
        return res;
    endfunction

    function automatic t_request request_of(logic [63:0] now, logic [SIZE_BITS-1:0] size,
                                            logic wr, logic [bls_pkg::PRI_W-1:0] lat,
                                            logic [bls_pkg::PRI_W-1:0] dur);
        t_request r;
        r.now_cycle      = now[STAMP_BITS-1:0];
        r.request_size   = size;
        r.write_req      = wr;
        r.prior_latency  = lat;
        r.prior_duration = dur;
        return r;
    endfunction

    function automatic logic [63:0] latest_stamp();
        return (read_free > write_free) ? read_free : write_free;
    endfunction

    function automatic t_request make_random_request();
        t_request    r;
        logic [63:0] wide;
        int          pick;
        pick = $urandom_range(0, 99);
        if (cfg_bw == 0) begin
            // state is frozen here, so let the stamp roam the whole range
            wide = {$urandom, $urandom};
            r.now_cycle = wide[STAMP_BITS-1:0];
        end else begin
            if (pick < 5) begin
                clock_now = latest_stamp() + 64'($urandom_range(0, 100));
            end else if (pick < 10) begin
                clock_now = (clock_now > 100) ? clock_now - 64'($urandom_range(0, 100))
                                              : 64'd0;
            end else begin
                clock_now = clock_now + 64'($urandom_range(0, 40));
            end
            r.now_cycle = clock_now[STAMP_BITS-1:0];
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            r.request_size = '0;
        end else if (pick < 20) begin
            r.request_size = '1;
        end else if (pick < 40) begin
            r.request_size = SIZE_BITS'($urandom);
        end else if (pick < 55) begin
            r.request_size = SIZE_BITS'(int'(cfg_bw) * $urandom_range(1, 16));
        end else begin
            r.request_size = SIZE_BITS'($urandom_range(0, 8 * int'(cfg_bw) + 8));
        end
        r.write_req = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.prior_latency = bls_pkg::PRI_W'($urandom);
        end else if (pick < 70) begin
            r.prior_latency = bls_pkg::PRI_W'($urandom_range(0, 64));
        end else if (pick < 85) begin
            r.prior_latency = '0;
        end else begin
            r.prior_latency = '1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.prior_duration = bls_pkg::PRI_W'($urandom);
        end else if (pick < 70) begin
            r.prior_duration = bls_pkg::PRI_W'($urandom_range(0, 64));
        end else if (pick < 85) begin
            r.prior_duration = '0;
        end else begin
            r.prior_duration = '1;
        end
        return r;
    endfunction

    task automatic send_request(t_request r);
        if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.now_cycle      <= r.now_cycle;
        req_if.request_size   <= r.request_size;
        req_if.write_req      <= r.write_req;
        req_if.prior_latency  <= r.prior_latency;
        req_if.prior_duration <= r.prior_duration;
        do @(posedge i_clk); while (!req_if.ready);
        shaped_results_q.insert(shaped_results_q.size(), shape_request(r));
        sent_count++;
    endtask

    task automatic wait_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (shaped_results_q.size() != 0);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= bls_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            bls_pkg::REG_BYTES_PER_CYCLE: cfg_bw = value;
            bls_pkg::REG_FIXED_LATENCY:   cfg_fixed = value;
            bls_pkg::REG_SHARED_RW:       cfg_shared = value[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] bw, logic [7:0] fixed_lat, logic shared);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_write(bls_pkg::REG_BYTES_PER_CYCLE, bw);
        reg_write(bls_pkg::REG_FIXED_LATENCY, fixed_lat);
        reg_write(bls_pkg::REG_SHARED_RW, 8'(shared));
        settings_count++;
    endtask

    // Result side: check every accepted result, then pick ready for the next cycle
    initial begin : result_sink
        int      stall_left;
        int      hold_left;
        t_shaped want;
        stall_left = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (shaped_results_q.size() == 0) begin
                    report_mismatch("result with none expected",
                                    64'(rsp_if.new_latency), 64'd0);
                end else begin
                    want = shaped_results_q.pop_front();
                    if (rsp_if.new_latency !== want.new_latency) begin
                        report_mismatch("new_latency", 64'(rsp_if.new_latency),
                                        64'(want.new_latency));
                    end
                    if (rsp_if.new_duration !== want.new_duration) begin
                        report_mismatch("new_duration", 64'(rsp_if.new_duration),
                                        64'(want.new_duration));
                    end
                    checked_count++;
                end
            end
            if (hold_off_req > 0) begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (!quiet && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 13) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_defaults();
        // 4 bytes per cycle, no fixed latency, split timelines
        send_request(request_of(64'd0, 16'd0, 1'b0, 16'd0, 16'd0));
        send_request(request_of(64'd0, 16'd10, 1'b0, 16'd0, 16'd0));
        send_request(request_of(64'd0, 16'd8, 1'b1, 16'd5, 16'd0));
        send_request(request_of(64'd1, 16'hFFFF, 1'b0, 16'd0, 16'd1));
        send_request(request_of(64'd2, 16'd4, 1'b0, 16'hFFFF, 16'hFFFF));
        clock_now = latest_stamp();
    endtask

    task automatic test_directed_settings();
        // shaping off: only the fixed latency is added
        set_config(8'd0, 8'd255, 1'b0);
        send_request(request_of(clock_now, 16'd100, 1'b1, 16'hFFFF, 16'hFFFF));
        send_request(request_of(clock_now + 5, 16'hFFFF, 1'b0, 16'd0, 16'd0));
        // widest bandwidth, shared timeline
        set_config(8'd255, 8'd0, 1'b1);
        send_request(request_of(clock_now, 16'd255, 1'b0, 16'd0, 16'd0));
        send_request(request_of(clock_now, 16'd256, 1'b0, 16'd0, 16'd0));
        send_request(request_of(clock_now, 16'd0, 1'b1, 16'd0, 16'd0));
        // remainder rounds the burst up
        set_config(8'd3, 8'd7, 1'b0);
        send_request(request_of(clock_now, 16'd10, 1'b1, 16'd0, 16'd2));
        // narrowest bandwidth, longest burst
        set_config(8'd1, 8'd1, 1'b0);
        send_request(request_of(clock_now, 16'hFFFF, 1'b0, 16'd0, 16'd0));
        send_request(request_of(clock_now + 3, 16'd1, 1'b0, 16'd0, 16'd0));
    endtask

    task automatic test_random_phases();
        logic [7:0] bw;
        logic [7:0] fixed_lat;
        logic       shared;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    bw = 8'd1; fixed_lat = 8'd0; shared = 1'b0;
                end
                1: begin
                    bw = 8'd255; fixed_lat = 8'd255; shared = 1'b1;
                end
                2: begin
                    bw = 8'd0; fixed_lat = 8'($urandom_range(0, 255));
                    shared = 1'($urandom_range(0, 1));
                end
                3: begin
                    bw = 8'd4; fixed_lat = 8'd0; shared = 1'b1;
                end
                default: begin
                    bw = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 16))
                                                     : 8'($urandom_range(1, 255));
                    fixed_lat = 8'($urandom_range(0, 255));
                    shared = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(bw, fixed_lat, shared);
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 5;
                2: stall_pct = 20;
                default: stall_pct = 40;
            endcase
            clock_now = latest_stamp();
            repeat (PHASE_ITEMS) send_request(make_random_request());
        end
        idle_pct  = 25;
        stall_pct = 10;
    endtask

    task automatic test_output_hold();
        set_config(8'd2, 8'd3, 1'b0);
        clock_now = latest_stamp();
        // hold the result side while requests keep coming, so the input stalls
        idle_pct = 0;
        hold_off_req = HOLD_CYCLES;
        repeat (24) send_request(make_random_request());
        idle_pct = 25;
        wait_results();
    endtask

    task automatic test_sender_pause();
        repeat (4) begin
            repeat (5) send_request(make_random_request());
            wait_results();
        end
    endtask

    task automatic test_timeline_limits();
        quiet = 1'b1;
        set_config(8'd1, 8'd255, 1'b0);
        // push the read timeline far ahead, then a wait beyond the latency range
        send_request(request_of(64'h8000_0000_0000, 16'd0, 1'b0, 16'd0, 16'd0));
        send_request(request_of(64'd0, 16'd1, 1'b0, 16'd0, 16'd0));
        // write timeline runs into the top of the stamp range and stays there
        send_request(request_of(STAMP_LIMIT, 16'hFFFF, 1'b1, 16'hFFFF, 16'd0));
        send_request(request_of(STAMP_LIMIT, 16'd0, 1'b1, 16'd0, 16'hFFFF));
        // shared mode: a read follows the saturated write timeline
        set_config(8'd1, 8'd255, 1'b1);
        send_request(request_of(STAMP_LIMIT - 10, 16'd5, 1'b0, 16'd0, 16'd0));
        send_request(request_of(STAMP_LIMIT - 10, 16'd5, 1'b0, 16'd20, 16'd1));
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        req_if.valid          <= 1'b0;
        req_if.now_cycle      <= '0;
        req_if.request_size   <= '0;
        req_if.write_req      <= 1'b0;
        req_if.prior_latency  <= '0;
        req_if.prior_duration <= '0;
        cfg_bw     = bls_pkg::BW_RESET;
        cfg_fixed  = '0;
        cfg_shared = 1'b0;
        read_free  = '0;
        write_free = '0;
        clock_now  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_settings();
        test_random_phases();
        test_output_hold();
        test_sender_pause();
        test_timeline_limits();

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests, %0d shaped results checked, %0d register settings",
                 sent_count, checked_count, settings_count);
        $display("incl. shaping off, shared timelines, saturation, zero size and output hold-off");
        if (errors == 0 && shaped_results_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/bls_pkg.sv
sv/bls_if.sv
sv/bls_cfg.sv
sv/bls_div.sv
sv/bandwidth_latency_shaper.sv
dv/tb_bandwidth_latency_shaper.sv
